// ----- sv/roi_grid_dark_pixel_occupancy_macros.svh -----
// assertion helpers shared by the block's rtl
`ifndef ROI_GRID_DARK_PIXEL_OCCUPANCY_MACROS_SVH
`define ROI_GRID_DARK_PIXEL_OCCUPANCY_MACROS_SVH

// checked on every edge outside reset
`define RGDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define RGDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/roigdp_pkg.sv -----
// ----------------------------------------------------------------------------
// roigdp_pkg
// Types, constants and helpers for the region-of-interest dark pixel grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package roigdp_pkg;

  localparam int unsigned GRID_CELLS = 9;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned SIDE_W  = 9;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned CIDX_W  = 4;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [POS_W-1:0]  FRAME_WIDTH_RST = 10'd640;
  localparam logic [POS_W-1:0]  ROI_LEFT_RST    = 10'd251;
  localparam logic [POS_W-1:0]  ROI_TOP_RST     = 10'd189;
  localparam logic [SIDE_W-1:0] ROI_SIDE_RST    = 9'd138;
  localparam logic [CNT_W-1:0]  THRESHOLD_RST   = 15'd265;

  localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

  // ceil(2^11 / 3), exact floor(x / 3) for any x below 2048
  localparam logic [10:0] Recip3 = 11'd683;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_ROI_LEFT    = 3'd1,
    REG_ROI_TOP     = 3'd2,
    REG_ROI_SIDE    = 3'd3,
    REG_THRESHOLD   = 3'd4
  } reg_idx_e;

  // floor(x / 3) by reciprocal multiply
  function automatic logic [SIDE_W-1:0] third_of(input logic [SIDE_W:0] x);
    logic [20:0] prod;
    prod = 21'(x) * 21'(Recip3);
    return prod[19:11];
  endfunction

endpackage

// ----- sv/roi_grid_dark_pixel_occupancy.sv -----
// ----------------------------------------------------------------------------
// roi_grid_dark_pixel_occupancy
// Counts zero-valued pixels in the nine cells of a 3x3 grid laid over a
// square region of a raster frame, and reports the counts at frame end.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       slave      in_valid_i / in_ready_o  pixel_value_i, frame_end_i
//  out      master     out_valid_o / out_ready_i cell_index_o, dark_count_o,
//                                               occupied_o, last_cell_o
//  cfg      apb slave  psel/penable/pwrite      paddr, pwdata, prdata
//
//  one pixel beat per cycle unless stalled; two stages: cell lookup, then
//  counter update; a frame-end beat yields nine result beats, one per cycle
//  unless stalled, from a snapshot; the next frame counts while it drains;
//  a second frame end waits in the update stage until the snapshot is free
//  reset clears positions, counters and handshake state; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roi_grid_dark_pixel_occupancy #(
  parameter int unsigned GRID_CELLS = roigdp_pkg::GRID_CELLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [roigdp_pkg::PIX_W-1:0]    pixel_value_i,
  input  logic                            frame_end_i,
  // cell results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [roigdp_pkg::CIDX_W-1:0]   cell_index_o,
  output logic [roigdp_pkg::CNT_W-1:0]    dark_count_o,
  output logic                            occupied_o,
  output logic                            last_cell_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [roigdp_pkg::ADDR_W-1:0]   paddr,
  input  logic [roigdp_pkg::DATA_W-1:0]   pwdata,
  output logic [roigdp_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);

  localparam int unsigned IdxW  = $clog2(GRID_CELLS);
  localparam int unsigned PosW  = roigdp_pkg::POS_W;
  localparam int unsigned SideW = roigdp_pkg::SIDE_W;
  localparam int unsigned CntW  = roigdp_pkg::CNT_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(GRID_CELLS - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [PosW-1:0]  frame_width_q, roi_left_q, roi_top_q;
  logic [SideW-1:0] roi_side_q, third1_q, third2_q;
  logic [CntW-1:0]  threshold_q;
  logic             cfg_wr;
  roigdp_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = roigdp_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= roigdp_pkg::FRAME_WIDTH_RST;
      roi_left_q    <= roigdp_pkg::ROI_LEFT_RST;
      roi_top_q     <= roigdp_pkg::ROI_TOP_RST;
      roi_side_q    <= roigdp_pkg::ROI_SIDE_RST;
      third1_q      <= roigdp_pkg::third_of({1'b0, roigdp_pkg::ROI_SIDE_RST});
      third2_q      <= roigdp_pkg::third_of({roigdp_pkg::ROI_SIDE_RST, 1'b0});
      threshold_q   <= roigdp_pkg::THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        roigdp_pkg::REG_FRAME_WIDTH: frame_width_q <= pwdata[PosW-1:0];
        roigdp_pkg::REG_ROI_LEFT:    roi_left_q    <= pwdata[PosW-1:0];
        roigdp_pkg::REG_ROI_TOP:     roi_top_q     <= pwdata[PosW-1:0];
        roigdp_pkg::REG_ROI_SIDE: begin
          roi_side_q <= pwdata[SideW-1:0];
          // band edges at side/3 and 2*side/3
          third1_q   <= roigdp_pkg::third_of({1'b0, pwdata[SideW-1:0]});
          third2_q   <= roigdp_pkg::third_of({pwdata[SideW-1:0], 1'b0});
        end
        roigdp_pkg::REG_THRESHOLD:   threshold_q   <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      roigdp_pkg::REG_FRAME_WIDTH: prdata = 32'(frame_width_q);
      roigdp_pkg::REG_ROI_LEFT:    prdata = 32'(roi_left_q);
      roigdp_pkg::REG_ROI_TOP:     prdata = 32'(roi_top_q);
      roigdp_pkg::REG_ROI_SIDE:    prdata = 32'(roi_side_q);
      roigdp_pkg::REG_THRESHOLD:   prdata = 32'(threshold_q);
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // stage 0: position tracking and cell lookup
  // --------------------------------------------------------------------------
  logic            in_acc;
  logic [PosW-1:0] col_q, row_q, col_d, row_d;
  logic [PosW:0]   col_inc;
  logic [PosW-1:0] col_off, row_off;
  logic            in_roi;
  logic [1:0]      col_band, row_band;
  logic [IdxW-1:0] cell_idx;

  assign in_acc  = in_valid_i && in_ready_o;
  assign col_off = col_q - roi_left_q;
  assign row_off = row_q - roi_top_q;
  assign in_roi  = (col_q >= roi_left_q) && (col_off < PosW'(roi_side_q)) &&
                   (row_q >= roi_top_q)  && (row_off < PosW'(roi_side_q));

  always_comb begin
    priority if (col_off < PosW'(third1_q)) col_band = 2'd0;
    else if (col_off < PosW'(third2_q))     col_band = 2'd1;
    else                                    col_band = 2'd2;
    priority if (row_off < PosW'(third1_q)) row_band = 2'd0;
    else if (row_off < PosW'(third2_q))     row_band = 2'd1;
    else                                    row_band = 2'd2;
  end

  assign cell_idx = IdxW'({row_band, 1'b0}) + IdxW'(row_band) + IdxW'(col_band);

  always_comb begin
    col_inc = {1'b0, col_q} + 1'b1;
    col_d   = col_inc[PosW-1:0];
    row_d   = row_q;
    if (col_inc >= {1'b0, frame_width_q}) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end
    if (frame_end_i) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: counter update and snapshot at frame end
  // --------------------------------------------------------------------------
  logic            s1_valid_q, s1_hit_q, s1_fend_q, s1_adv;
  logic [IdxW-1:0] s1_cell_q;
  logic            emit_busy_q;

  assign s1_adv     = s1_valid_q && !(s1_fend_q && emit_busy_q);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_hit_q  <= in_roi && (pixel_value_i == '0);
      s1_fend_q <= frame_end_i;
      s1_cell_q <= cell_idx;
    end
  end

  logic [CntW-1:0] cnt_q [GRID_CELLS];
  logic [CntW-1:0] cnt_upd [GRID_CELLS];
  logic [CntW-1:0] snap_q [GRID_CELLS];

  always_comb begin
    for (int k = 0; k < GRID_CELLS; k++) begin
      cnt_upd[k] = cnt_q[k];
    end
    // saturating increment of the addressed cell
    if (s1_adv && s1_hit_q && (cnt_q[s1_cell_q] != roigdp_pkg::CNT_MAX)) begin
      cnt_upd[s1_cell_q] = cnt_q[s1_cell_q] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < GRID_CELLS; k++) cnt_q[k] <= '0;
    end else if (s1_adv) begin
      for (int k = 0; k < GRID_CELLS; k++) begin
        cnt_q[k] <= s1_fend_q ? '0 : cnt_upd[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_fend_q) begin
      for (int k = 0; k < GRID_CELLS; k++) snap_q[k] <= cnt_upd[k];
    end
  end

  // --------------------------------------------------------------------------
  // result emitter: walks the snapshot into the output register
  // --------------------------------------------------------------------------
  logic            out_load, out_valid_q;
  logic [IdxW-1:0] emit_idx_q;

  assign out_load = emit_busy_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_busy_q <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv && s1_fend_q) begin
        emit_busy_q <= 1'b1;
        emit_idx_q  <= '0;
      end else if (out_load) begin
        if (emit_idx_q == LastIdx) begin
          emit_busy_q <= 1'b0;
          emit_idx_q  <= '0;
        end else begin
          emit_idx_q <= emit_idx_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_index_o <= roigdp_pkg::CIDX_W'(emit_idx_q);
      dark_count_o <= snap_q[emit_idx_q];
      occupied_o   <= snap_q[emit_idx_q] >= threshold_q;
      last_cell_o  <= emit_idx_q == LastIdx;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `include "roi_grid_dark_pixel_occupancy_macros.svh"

  `RGDP_ASSERT(a_snap_guard, (s1_valid_q && s1_fend_q && emit_busy_q) |-> !s1_adv, "snapshot overwritten while draining")
  `RGDP_ASSERT(a_emit_start, (s1_adv && s1_fend_q) |=> emit_busy_q, "frame end did not start the emitter")
  `RGDP_ASSERT(a_last_idx, (out_valid_o && last_cell_o) |-> (cell_index_o == roigdp_pkg::CIDX_W'(LastIdx)), "last beat on wrong cell")
  `RGDP_ASSERT(a_pos_clear, (in_acc && frame_end_i) |=> (col_q == '0 && row_q == '0), "positions not cleared at frame end")
  `RGDP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (!out_valid_o && !emit_busy_q), "emitter active in reset")

endmodule
